// ----- hw/rtl/swcl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcl_pkg: shared types and constants of the single-wire command link
// Phase encodings, receive status codes and the per-tick item and result.
// ----------------------------------------------------------------------------
package swcl_pkg;

	localparam int TICK_W = 16;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	localparam logic [TICK_W-1:0] BIT_TICKS_RST = 16'd50;

	typedef enum logic [1:0] {
		TX_IDLE,
		TX_START,
		TX_DATA,
		TX_STOP
	} tx_phase_t;

	typedef enum logic [2:0] {
		RX_IDLE,
		RX_START,
		RX_DATA,
		RX_STOP,
		RX_TAIL
	} rx_phase_t;

	typedef enum logic [STAT_W-1:0] {
		ST_NONE,
		ST_OK,
		ST_NO_START,
		ST_NO_STOP
	} rx_status_t;

	// LED toggle commands
	localparam logic [7:0] CMD_LED_ONE = 8'b0000_0001;
	localparam logic [7:0] CMD_LED_TWO = 8'b0000_0010;

	typedef struct packed {
		logic             line_in;
		logic             send_valid;
		logic [CMD_W-1:0] send_cmd;
	} swcl_item_t;

	typedef struct packed {
		logic             line_release;
		logic             tx_busy;
		logic             rx_busy;
		rx_status_t       rx_status;
		logic [CMD_W-1:0] rx_cmd;
		logic             led_one;
		logic             led_two;
	} swcl_result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/swcl_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcl_in_if: per-tick input channel
// Valid/ready channel carrying the sampled line level and a send request.
// ----------------------------------------------------------------------------
interface swcl_in_if;
	logic                        valid;
	logic                        ready;
	logic                        line_in;
	logic                        send_valid;
	logic [swcl_pkg::CMD_W-1:0]  send_cmd;

	modport source (output valid, line_in, send_valid, send_cmd, input ready);
	modport sink   (input valid, line_in, send_valid, send_cmd, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/swcl_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcl_out_if: per-tick result channel
// Valid/ready channel carrying line drive, busy flags, receive report, LEDs.
// ----------------------------------------------------------------------------
interface swcl_out_if;
	logic                        valid;
	logic                        ready;
	logic                        line_release;
	logic                        tx_busy;
	logic                        rx_busy;
	logic [swcl_pkg::STAT_W-1:0] rx_status;
	logic [swcl_pkg::CMD_W-1:0]  rx_cmd;
	logic                        led_one;
	logic                        led_two;

	modport source (output valid, line_release, tx_busy, rx_busy, rx_status, rx_cmd,
		led_one, led_two, input ready);
	modport sink   (input valid, line_release, tx_busy, rx_busy, rx_status, rx_cmd,
		led_one, led_two, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/single_wire_command_link.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// single_wire_command_link: command transceiver for one open-drain wire
// Input register, per-tick frame engine and result register.
// ----------------------------------------------------------------------------
// Each input transfer is one tick of the line. The block takes one transfer
// per clock cycle when the output side is not stalled and answers each with
// exactly one result transfer: the tick is captured in the input register
// (_s1), the engine applies it to the transmit/receive state in a single
// pass, and the answer lands in the result register (_s2).
// The input side stays ready while a result waits, as long as the result
// register is free or being drained in the same cycle. A send request starts
// a frame (low start bit, DATA_BITS data bits LSB first, released stop bit)
// only when both sides are idle; otherwise it is dropped. A low line while
// idle starts a receive, which is checked at half a bit, sampled mid-bit,
// checked at the stop bit and reported half a bit later; a failed check is
// reported on the tick of the sample. Received command 1 toggles led_one,
// command 2 toggles led_two. bit_ticks is written through cfg_we/cfg_data and
// should only change while the link is idle.
// ----------------------------------------------------------------------------
module single_wire_command_link #(
	parameter int DATA_BITS = 2
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	swcl_in_if.sink                          in_ch,
	swcl_out_if.source                       out_ch,
	input  wire logic                        cfg_we,
	input  wire logic [swcl_pkg::TICK_W-1:0] cfg_data
);
	import swcl_pkg::*;

	logic [TICK_W-1:0] bit_ticks_q;
	logic              valid_s1, valid_s2;
	swcl_item_t        item_s1, item_in;
	swcl_result_t      res, res_s2;
	logic              adv, in_xfer;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q <= BIT_TICKS_RST;
		end else if (cfg_we) begin
			bit_ticks_q <= cfg_data;
		end
	end

	// stage 1 advances whenever the result register can take its answer
	assign adv          = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || adv;
	assign in_xfer      = in_ch.valid && in_ch.ready;

	assign item_in.line_in    = in_ch.line_in;
	assign item_in.send_valid = in_ch.send_valid;
	assign item_in.send_cmd   = in_ch.send_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= item_in;
		end
	end

	swcl_engine #(
		.DATA_BITS(DATA_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.item     (item_s1),
		.bit_ticks(bit_ticks_q),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.line_release = res_s2.line_release;
	assign out_ch.tx_busy      = res_s2.tx_busy;
	assign out_ch.rx_busy      = res_s2.rx_busy;
	assign out_ch.rx_status    = res_s2.rx_status;
	assign out_ch.rx_cmd       = res_s2.rx_cmd;
	assign out_ch.led_one      = res_s2.led_one;
	assign out_ch.led_two      = res_s2.led_two;

	// transmit and receive never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.tx_busy && res_s2.rx_busy))
		else $error("tx and rx busy together");

	// a command is only shown with a good receive
	a_cmd_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.rx_status == ST_OK || res_s2.rx_cmd == '0))
		else $error("rx_cmd set without ST_OK");

	// any report ends the receive
	a_report_ends_rx: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.rx_status != ST_NONE) |-> !res_s2.rx_busy)
		else $error("receive still busy after report");

	// the engine only advances into a free or draining result register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ch.ready) |=> (valid_s2 && $stable(res_s2)))
		else $error("stalled result overwritten");

endmodule
`default_nettype wire

// ----- hw/rtl/swcl_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcl_engine: transmit/receive state and per-tick update
// Holds both frame machines and the LEDs; one tick is applied when en is high.
// ----------------------------------------------------------------------------
module swcl_engine #(
	parameter int DATA_BITS = 2
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire swcl_pkg::swcl_item_t        item,
	input  wire logic [swcl_pkg::TICK_W-1:0] bit_ticks,
	output      swcl_pkg::swcl_result_t      res
);
	import swcl_pkg::*;

	localparam int IDX_W = $clog2(DATA_BITS + 1);

	tx_phase_t           tx_phase_q, tx_phase_d;
	rx_phase_t           rx_phase_q, rx_phase_d;
	logic [TICK_W-1:0]   tx_timer_q, tx_timer_d, rx_timer_q, rx_timer_d;
	logic [DATA_BITS-1:0] tx_shifter_q, tx_shifter_d, rx_shifter_q, rx_shifter_d;
	logic [IDX_W-1:0]    bit_index_q, bit_index_d;
	logic [1:0]          ind_q, ind_d;

	logic [TICK_W-1:0]    full_bit, half_bit, tx_load;
	logic                 tx_idle, rx_was_active, start_tx, start_rx, tx_active;
	logic                 tx_due, rx_due;
	tx_phase_t            tx_ph_eff;
	logic [DATA_BITS-1:0] tx_sh_eff, cmd_load;
	logic [IDX_W-1:0]     idx_eff, idx_inc;
	logic [7:0]           cmd_ext, rx_sh_ext;

	assign full_bit = (bit_ticks == '0) ? TICK_W'(1) : bit_ticks;
	assign half_bit = ((bit_ticks >> 1) == '0) ? TICK_W'(1) : (bit_ticks >> 1);

	assign tx_idle       = (tx_phase_q == TX_IDLE);
	assign rx_was_active = (rx_phase_q != RX_IDLE);
	assign start_tx      = tx_idle && !rx_was_active && item.send_valid;
	assign start_rx      = tx_idle && !rx_was_active && !item.send_valid && !item.line_in;
	assign tx_active     = start_tx || !tx_idle;

	assign cmd_ext   = {{(8-CMD_W){1'b0}}, item.send_cmd};
	assign cmd_load  = cmd_ext[DATA_BITS-1:0];
	assign tx_ph_eff = start_tx ? TX_START : tx_phase_q;
	assign tx_load   = start_tx ? full_bit : tx_timer_q;
	assign tx_sh_eff = start_tx ? cmd_load : tx_shifter_q;
	assign idx_eff   = start_tx ? '0 : bit_index_q;
	assign idx_inc   = idx_eff + IDX_W'(1);
	assign tx_due    = (tx_load == TICK_W'(1));
	assign rx_due    = rx_was_active && (rx_timer_q == TICK_W'(1));
	assign rx_sh_ext = 8'(rx_shifter_q);

	// next state
	always_comb begin
		tx_phase_d   = tx_phase_q;
		tx_timer_d   = tx_timer_q;
		tx_shifter_d = tx_shifter_q;
		rx_phase_d   = rx_phase_q;
		rx_timer_d   = rx_timer_q;
		rx_shifter_d = rx_shifter_q;
		bit_index_d  = idx_eff;
		ind_d        = ind_q;
		if (tx_active) begin
			tx_phase_d   = tx_ph_eff;
			tx_shifter_d = tx_sh_eff;
			tx_timer_d   = tx_load - TICK_W'(1);
			if (tx_due) begin
				case (tx_ph_eff)
					TX_START: begin
						tx_phase_d = TX_DATA;
						tx_timer_d = full_bit;
					end
					TX_DATA: begin
						tx_shifter_d = tx_sh_eff >> 1;
						bit_index_d  = idx_inc;
						tx_phase_d   = (idx_inc >= IDX_W'(DATA_BITS)) ? TX_STOP : TX_DATA;
						tx_timer_d   = full_bit;
					end
					default: tx_phase_d = TX_IDLE;
				endcase
			end
		end else if (start_rx) begin
			rx_phase_d   = RX_START;
			rx_timer_d   = half_bit;
			rx_shifter_d = '0;
		end else if (rx_was_active) begin
			rx_timer_d = rx_timer_q - TICK_W'(1);
			if (rx_due) begin
				case (rx_phase_q)
					RX_START: begin
						if (!item.line_in) begin
							rx_phase_d  = RX_DATA;
							rx_timer_d  = full_bit;
							bit_index_d = '0;
						end else begin
							rx_phase_d = RX_IDLE;
						end
					end
					RX_DATA: begin
						// LSB first: shift in from the top
						rx_shifter_d = (rx_shifter_q >> 1)
							| (DATA_BITS'(item.line_in) << (DATA_BITS - 1));
						bit_index_d  = idx_inc;
						rx_phase_d   = (idx_inc >= IDX_W'(DATA_BITS)) ? RX_STOP : RX_DATA;
						rx_timer_d   = full_bit;
					end
					RX_STOP: begin
						if (item.line_in) begin
							rx_phase_d = RX_TAIL;
							rx_timer_d = half_bit;
						end else begin
							rx_phase_d = RX_IDLE;
						end
					end
					default: begin
						ind_d      = ind_q ^ {rx_sh_ext == CMD_LED_TWO, rx_sh_ext == CMD_LED_ONE};
						rx_phase_d = RX_IDLE;
					end
				endcase
			end
		end
	end

	// outputs
	always_comb begin
		res              = '0;
		res.line_release = 1'b1;
		res.tx_busy      = tx_active;
		res.rx_status    = ST_NONE;
		if (tx_active) begin
			case (tx_ph_eff)
				TX_START: res.line_release = 1'b0;
				TX_DATA:  res.line_release = tx_sh_eff[0];
				default:  res.line_release = 1'b1;
			endcase
		end else if (rx_due) begin
			case (rx_phase_q)
				RX_START: res.rx_status = item.line_in ? ST_NO_START : ST_NONE;
				RX_DATA:  res.rx_status = ST_NONE;
				RX_STOP:  res.rx_status = item.line_in ? ST_NONE : ST_NO_STOP;
				default: begin
					res.rx_status = ST_OK;
					res.rx_cmd    = rx_sh_ext[CMD_W-1:0];
				end
			endcase
		end
		res.rx_busy = (rx_phase_d != RX_IDLE);
		res.led_one = ind_d[0];
		res.led_two = ind_d[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_phase_q   <= TX_IDLE;
			tx_timer_q   <= '0;
			tx_shifter_q <= '0;
			rx_phase_q   <= RX_IDLE;
			rx_timer_q   <= '0;
			rx_shifter_q <= '0;
			bit_index_q  <= '0;
			ind_q        <= '0;
		end else if (en) begin
			tx_phase_q   <= tx_phase_d;
			tx_timer_q   <= tx_timer_d;
			tx_shifter_q <= tx_shifter_d;
			rx_phase_q   <= rx_phase_d;
			rx_timer_q   <= rx_timer_d;
			rx_shifter_q <= rx_shifter_d;
			bit_index_q  <= bit_index_d;
			ind_q        <= ind_d;
		end
	end

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the single-wire command link
// Drives line ticks and send requests over the input channel, predicts every
// per-tick result in a local model of the link and checks each result
// transfer field by field. A short stimulus table comes first, then random
// frames, glitches, sends and noise at several bit periods.
// ----------------------------------------------------------------------------
module tb_top;
	import swcl_pkg::*;

	localparam int  DATA_BITS     = 2;
	localparam real CLK_PERIOD    = 12.0;
	localparam int  RESET_CYCLES  = 11;
	// the limit leaves ample margin over the slowest legal run
	localparam int  CYCLE_LIMIT   = 3_000_000;
	localparam int  LONG_HOLD     = 120;
	// pipeline is two registers deep; the settle wait covers it
	localparam int  SETTLE_CYCLES = 4;
	localparam int  HOLD_PHASE    = 1;

	// random phases: bit period and tick budget; budget 0 marks the slow
	// period, which only gets one failed start check
	localparam int NUM_PHASES = 7;
	localparam logic [TICK_W-1:0] PHASE_TICKS [NUM_PHASES] =
		'{16'd3, 16'd5, 16'd301, 16'd2, 16'd7, 16'd50, 16'd4};
	localparam int PHASE_BUDGET [NUM_PHASES] = '{300, 300, 0, 250, 250, 400, 300};

	// ------------------------------------------------------------------------
	// Stimulus table
	// ------------------------------------------------------------------------
	typedef enum logic {
		ROW_TICK,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic             line;
		logic             req;
		logic [CMD_W-1:0] cmd;
		logic [TICK_W-1:0] ticks;   // new bit period for ROW_CFG
		logic             typed;    // want below is used instead of the model
		swcl_result_t     want;
	} plan_row_t;

	localparam swcl_result_t IDLE_REPORT =
		'{1'b1, 1'b0, 1'b0, ST_NONE, 2'd0, 1'b0, 1'b0};
	localparam swcl_result_t RX_ARMED =
		'{1'b1, 1'b0, 1'b1, ST_NONE, 2'd0, 1'b0, 1'b0};
	localparam swcl_result_t START_LOST =
		'{1'b1, 1'b0, 1'b0, ST_NO_START, 2'd0, 1'b0, 1'b0};
	// led_one is lit by the good command-1 frame just before
	localparam swcl_result_t STOP_LOST =
		'{1'b1, 1'b0, 1'b0, ST_NO_STOP, 2'd0, 1'b1, 1'b0};
	localparam swcl_result_t TX_LEADING =
		'{1'b0, 1'b1, 1'b0, ST_NONE, 2'd0, 1'b1, 1'b0};

	localparam int PLAN_LEN = 26;
	plan_row_t plan [PLAN_LEN] = '{
		// out of reset at the default period: quiet line, then a low line arms rx
		'{ROW_TICK, 1'b1, 1'b0, 2'd0, 16'd0, 1'b1, IDLE_REPORT},
		'{ROW_TICK, 1'b0, 1'b0, 2'd0, 16'd0, 1'b1, RX_ARMED},
		// drain runs out the half bit of the default period -> start lost
		'{ROW_CFG,  1'b1, 1'b0, 2'd0, 16'd2, 1'b0, '0},
		// start glitch: low for one tick, high at the half-bit check
		'{ROW_TICK, 1'b0, 1'b0, 2'd3, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b1, 1'b0, 2'd0, 16'd0, 1'b1, START_LOST},
		// good frame, command 1 (LSB first), two ticks per bit
		'{ROW_TICK, 1'b0, 1'b0, 2'd0, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b0, 1'b0, 2'd3, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b1, 1'b0, 2'd1, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b1, 1'b0, 2'd2, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b0, 1'b0, 2'd0, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b0, 1'b0, 2'd3, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b1, 1'b0, 2'd0, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b1, 1'b0, 2'd0, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b1, 1'b0, 2'd0, 16'd0, 1'b0, '0},
		// command 3 frame whose stop bit stays low
		'{ROW_TICK, 1'b0, 1'b0, 2'd0, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b0, 1'b0, 2'd0, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b1, 1'b0, 2'd0, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b1, 1'b0, 2'd0, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b1, 1'b0, 2'd0, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b1, 1'b0, 2'd0, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b0, 1'b0, 2'd0, 16'd0, 1'b0, '0},
		'{ROW_TICK, 1'b0, 1'b0, 2'd0, 16'd0, 1'b1, STOP_LOST},
		// send wins over a low line; a second request while busy is dropped
		'{ROW_TICK, 1'b0, 1'b1, 2'd2, 16'd0, 1'b1, TX_LEADING},
		'{ROW_TICK, 1'b0, 1'b1, 2'd1, 16'd0, 1'b0, '0},
		// odd period, top command value
		'{ROW_CFG,  1'b1, 1'b0, 2'd0, 16'd3, 1'b0, '0},
		'{ROW_TICK, 1'b1, 1'b1, 2'd3, 16'd0, 1'b1, TX_LEADING}
	};

	// ------------------------------------------------------------------------
	// DUT and channels
	// ------------------------------------------------------------------------
	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [TICK_W-1:0] cfg_data;

	swcl_in_if  in_ch ();
	swcl_out_if out_ch ();

	single_wire_command_link #(
		.DATA_BITS(DATA_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Link model: own copy of the register and of both frame engines
	// ------------------------------------------------------------------------
	logic [TICK_W-1:0] m_bit_ticks;
	tx_phase_t         m_tx_ph;
	logic [TICK_W-1:0] m_tx_cnt;
	logic [7:0]        m_tx_sh;
	rx_phase_t         m_rx_ph;
	logic [TICK_W-1:0] m_rx_cnt;
	logic [7:0]        m_rx_sh;
	logic [3:0]        m_bit_idx;   // shared, tx and rx never run together
	logic [1:0]        m_leds;

	swcl_result_t tick_result_q [$];
	int           mismatches;
	int           phase_ticks;
	bit           calm;             // no idling on either side
	int           hold_asked;
	int           hold_done;

	// zero periods are stretched to one tick
	function automatic logic [TICK_W-1:0] full_period();
		return (m_bit_ticks == '0) ? TICK_W'(1) : m_bit_ticks;
	endfunction

	function automatic logic [TICK_W-1:0] half_period();
		logic [TICK_W-1:0] h;
		h = m_bit_ticks >> 1;
		return (h == '0) ? TICK_W'(1) : h;
	endfunction

	// one line tick through the model; returns the result of that tick
	function automatic swcl_result_t link_model_tick(logic line, logic req,
			logic [CMD_W-1:0] cmd);
		swcl_result_t r;
		logic         rx_was_active;
		r.line_release = 1'b1;
		r.tx_busy      = 1'b0;
		r.rx_status    = ST_NONE;
		r.rx_cmd       = '0;
		rx_was_active  = (m_rx_ph != RX_IDLE);

		// a send is taken only with both sides idle, and beats a low line
		if (m_tx_ph == TX_IDLE && m_rx_ph == RX_IDLE) begin
			if (req) begin
				m_tx_ph   = TX_START;
				m_tx_cnt  = full_period();
				m_tx_sh   = 8'(cmd) & 8'((1 << DATA_BITS) - 1);
				m_bit_idx = '0;
			end else if (!line) begin
				m_rx_ph  = RX_START;
				m_rx_cnt = half_period();
				m_rx_sh  = '0;
			end
		end

		if (m_tx_ph != TX_IDLE) begin
			r.tx_busy = 1'b1;
			case (m_tx_ph)
				TX_START: r.line_release = 1'b0;
				TX_DATA:  r.line_release = m_tx_sh[0];
				default:  r.line_release = 1'b1;
			endcase
			m_tx_cnt = m_tx_cnt - 1'b1;
			if (m_tx_cnt == '0) begin
				case (m_tx_ph)
					TX_START: begin
						m_tx_ph  = TX_DATA;
						m_tx_cnt = full_period();
					end
					TX_DATA: begin
						m_tx_sh   = m_tx_sh >> 1;
						m_bit_idx = m_bit_idx + 1'b1;
						m_tx_ph   = (m_bit_idx >= DATA_BITS) ? TX_STOP : TX_DATA;
						m_tx_cnt  = full_period();
					end
					default: m_tx_ph = TX_IDLE;
				endcase
			end
		end else if (rx_was_active) begin
			// a receive armed on this tick does not count down yet
			m_rx_cnt = m_rx_cnt - 1'b1;
			if (m_rx_cnt == '0) begin
				case (m_rx_ph)
					RX_START: begin
						if (!line) begin
							m_rx_ph   = RX_DATA;
							m_rx_cnt  = full_period();
							m_bit_idx = '0;
						end else begin
							r.rx_status = ST_NO_START;
							m_rx_ph     = RX_IDLE;
						end
					end
					RX_DATA: begin
						m_rx_sh   = m_rx_sh | (8'(line) << m_bit_idx[2:0]);
						m_bit_idx = m_bit_idx + 1'b1;
						m_rx_ph   = (m_bit_idx >= DATA_BITS) ? RX_STOP : RX_DATA;
						m_rx_cnt  = full_period();
					end
					RX_STOP: begin
						if (line) begin
							m_rx_ph  = RX_TAIL;
							m_rx_cnt = half_period();
						end else begin
							r.rx_status = ST_NO_STOP;
							m_rx_ph     = RX_IDLE;
						end
					end
					default: begin
						// tail done: report, toggle on the two LED commands only
						r.rx_status = ST_OK;
						r.rx_cmd    = m_rx_sh[CMD_W-1:0];
						if (m_rx_sh == CMD_LED_ONE)
							m_leds[0] = ~m_leds[0];
						if (m_rx_sh == CMD_LED_TWO)
							m_leds[1] = ~m_leds[1];
						m_rx_ph = RX_IDLE;
					end
				endcase
			end
		end

		r.rx_busy = (m_rx_ph != RX_IDLE);
		r.led_one = m_leds[0];
		r.led_two = m_leds[1];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------
	// Called right after a rising edge; returns at the edge of the transfer
	// with valid still high, so the caller either offers the next tick or
	// lowers valid in that same step. The handshake is looked at on the
	// falling edge, where every signal is settled.
	task automatic offer_tick(logic line, logic req, logic [CMD_W-1:0] cmd,
			logic typed = 1'b0, swcl_result_t want = '0);
		swcl_result_t predicted;
		int           gap;
		gap = 0;
		if (!calm && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 8);
		if (gap > 0) begin
			in_ch.valid      <= 1'b0;
			in_ch.line_in    <= 1'($urandom);
			in_ch.send_valid <= 1'($urandom);
			in_ch.send_cmd   <= 2'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.line_in    <= line;
		in_ch.send_valid <= req;
		in_ch.send_cmd   <= cmd;
		@(negedge clk);
		while (in_ch.ready !== 1'b1)
			@(negedge clk);
		// transfer happens at the coming rising edge
		predicted = link_model_tick(line, req, cmd);
		tick_result_q.push_back(typed ? want : predicted);
		phase_ticks++;
		@(posedge clk);
	endtask

	// quiet line until both engines of the model are idle
	task automatic wait_link_idle();
		while (m_tx_ph != TX_IDLE || m_rx_ph != RX_IDLE)
			offer_tick(1'b1, 1'b0, 2'($urandom));
	endtask

	// New bit period: only with the link idle and every result drained
	task automatic retune(logic [TICK_W-1:0] ticks);
		wait_link_idle();
		in_ch.valid <= 1'b0;
		while (tick_result_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_we      <= 1'b0;
		m_bit_ticks = ticks;
	endtask

	// incoming frame with exact bit timing; rare stray send requests
	task automatic frame_in(logic [CMD_W-1:0] cmd, logic stop_ok);
		logic [CMD_W+1:0] levels;
		wait_link_idle();
		levels = {stop_ok, cmd, 1'b0};
		for (int b = 0; b < CMD_W + 2; b++)
			repeat (m_bit_ticks)
				offer_tick(levels[b], ($urandom_range(0, 31) == 0), 2'($urandom));
	endtask

	// start bit that goes away before the half-bit check
	task automatic glitch_start();
		int low_len;
		wait_link_idle();
		low_len = $urandom_range(1, half_period());
		repeat (low_len) offer_tick(1'b0, 1'b0, 2'($urandom));
		wait_link_idle();
	endtask

	// own frame; line and further requests are random while it runs
	task automatic send_frame(logic [CMD_W-1:0] cmd);
		wait_link_idle();
		offer_tick(1'($urandom), 1'b1, cmd);
		while (m_tx_ph != TX_IDLE)
			offer_tick(1'($urandom), ($urandom_range(0, 3) == 0), 2'($urandom));
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(1, 12))
			offer_tick(1'($urandom), ($urandom_range(0, 7) == 0), 2'($urandom));
	endtask

	// ------------------------------------------------------------------------
	// Output side: ready bursts, plus one long hold when asked
	// ------------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left   = 0;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (hold_asked != hold_done) begin
				// long hold: both pipeline stages fill and the input stalls
				hold_done++;
				stall_left   = LONG_HOLD - 1;
				out_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left   = $urandom_range(0, 7);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic check_field(string what, logic [1:0] want, logic [1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	// result transfer seen on the falling edge before the edge that takes it
	always @(negedge clk) begin
		swcl_result_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (tick_result_q.size() == 0) begin
				mismatches++;
				$display("%0t: result transfer expected none actual one", $time);
			end else begin
				want = tick_result_q.pop_front();
				check_field("line_release", want.line_release, out_ch.line_release);
				check_field("tx_busy", want.tx_busy, out_ch.tx_busy);
				check_field("rx_busy", want.rx_busy, out_ch.rx_busy);
				check_field("rx_status", want.rx_status, out_ch.rx_status);
				check_field("rx_cmd", want.rx_cmd, out_ch.rx_cmd);
				check_field("led_one", want.led_one, out_ch.led_one);
				check_field("led_two", want.led_two, out_ch.led_two);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("single_wire_command_link test failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int pick;
		bit held;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_data         = BIT_TICKS_RST;
		in_ch.valid      = 1'b0;
		in_ch.line_in    = 1'b1;
		in_ch.send_valid = 1'b0;
		in_ch.send_cmd   = '0;
		mismatches       = 0;
		phase_ticks      = 0;
		calm             = 1'b0;
		hold_asked       = 0;
		hold_done        = 0;
		held             = 1'b0;
		m_bit_ticks      = BIT_TICKS_RST;
		m_tx_ph          = TX_IDLE;
		m_tx_cnt         = '0;
		m_tx_sh          = '0;
		m_rx_ph          = RX_IDLE;
		m_rx_cnt         = '0;
		m_rx_sh          = '0;
		m_bit_idx        = '0;
		m_leds           = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				retune(plan[i].ticks);
			else
				offer_tick(plan[i].line, plan[i].req, plan[i].cmd, plan[i].typed,
					plan[i].want);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			// last phase runs flat out on both sides
			calm = (p == NUM_PHASES - 1);
			retune(PHASE_TICKS[p]);
			phase_ticks = 0;
			if (PHASE_BUDGET[p] == 0) begin
				// slow period: one-tick start glitch, checked a half bit later
				offer_tick(1'b0, 1'b0, 2'($urandom));
				wait_link_idle();
			end else begin
				while (phase_ticks < PHASE_BUDGET[p]) begin
					if (p == HOLD_PHASE && !held && phase_ticks >= 100) begin
						hold_asked++;
						held = 1'b1;
					end
					pick = $urandom_range(0, 99);
					if (pick < 45)
						frame_in(2'($urandom), 1'b1);
					else if (pick < 55)
						frame_in(2'($urandom), 1'b0);
					else if (pick < 65)
						glitch_start();
					else if (pick < 85)
						send_frame(2'($urandom));
					else
						noise_burst();
				end
			end
		end

		in_ch.valid <= 1'b0;
		while (tick_result_q.size() != 0)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("single_wire_command_link test passed");
		else
			$display("single_wire_command_link test failed");
		$finish;
	end

endmodule
